/* rtl/ntc_adc_pkg.sv */
`default_nettype none

package ntc_adc_pkg;

	// converter and field widths
	localparam int ADC_BITS     = 12;
	localparam int PULLUP_W     = 17;
	localparam int TEMP_W       = 16;
	localparam int TABLE_POINTS = 25;
	localparam int IDX_W        = $clog2(TABLE_POINTS);

	localparam logic [ADC_BITS-1:0] ADC_FULL = {ADC_BITS{1'b1}};
	localparam logic [PULLUP_W-1:0] PULLUP_RESET = PULLUP_W'(10000);

	// pullup * 10 fits in MCAND_W bits, times the sample in PROD_W bits
	localparam int MCAND_W = PULLUP_W + 4;
	localparam int PROD_W  = MCAND_W + ADC_BITS;
	localparam int STEPS_W = $clog2(PROD_W + 1);

	// resistance in tenths of an ohm and the widest segment span
	localparam int RES_W  = 21;
	localparam int DIV_W  = 19;
	localparam int QUO2_W = 11;
	localparam int NUM_W  = DIV_W + QUO2_W;

	// one table step is 5 C in Q8
	localparam int TEMP_STEP_Q8 = 1280;
	localparam int TEMP_MIN_Q8  = -5120;

	typedef enum logic [1:0] {
		RS_INTERP = 2'd0,
		RS_COLD   = 2'd1,
		RS_HOT    = 2'd2
	} range_status_t;

	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    init_rem;
		logic [PROD_W-1:0]   dividend;
		logic [DIV_W-1:0]    divisor;
		logic [STEPS_W-1:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [PROD_W-1:0]   quotient;
	} div_rsp_t;

	function automatic logic [RES_W-1:0] res_tenths(input logic [IDX_W-1:0] idx);
		logic [RES_W-1:0] r;
		begin
			case (idx)
				5'd0:    r = RES_W'(1146600);
				5'd1:    r = RES_W'(845100);
				5'd2:    r = RES_W'(629270);
				5'd3:    r = RES_W'(470770);
				5'd4:    r = RES_W'(355630);
				5'd5:    r = RES_W'(271190);
				5'd6:    r = RES_W'(208600);
				5'd7:    r = RES_W'(162040);
				5'd8:    r = RES_W'(126830);
				5'd9:    r = RES_W'(100000);
				5'd10:   r = RES_W'(79420);
				5'd11:   r = RES_W'(63270);
				5'd12:   r = RES_W'(50740);
				5'd13:   r = RES_W'(41030);
				5'd14:   r = RES_W'(33360);
				5'd15:   r = RES_W'(27240);
				5'd16:   r = RES_W'(22370);
				5'd17:   r = RES_W'(18460);
				5'd18:   r = RES_W'(15300);
				5'd19:   r = RES_W'(12750);
				5'd20:   r = RES_W'(10680);
				5'd21:   r = RES_W'(8993);
				5'd22:   r = RES_W'(7607);
				5'd23:   r = RES_W'(6452);
				5'd24:   r = RES_W'(5494);
				default: r = RES_W'(5494);
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [TEMP_W-1:0] temp_base(input logic [IDX_W-1:0] idx);
		int t;
		begin
			t = TEMP_MIN_Q8 + TEMP_STEP_Q8 * int'(idx);
			return TEMP_W'(t);
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/ntc_adc_div.sv */
`default_nettype none

module ntc_adc_div
	import ntc_adc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output      div_rsp_t rsp
);

	logic [DIV_W-1:0]   rem_q;
	logic [PROD_W-1:0]  dq_q;
	logic [DIV_W-1:0]   den_q;
	logic [STEPS_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [DIV_W:0]     trial;
	logic [DIV_W:0]     diff;
	logic               fits;

	// one quotient bit per cycle, MSB first
	always_comb begin
		trial = {rem_q, dq_q[PROD_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = ~diff[DIV_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == STEPS_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEPS_W'(1);
				if (cnt_q == STEPS_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.init_rem;
			dq_q  <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			dq_q  <= {dq_q[PROD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

`default_nettype wire

/* rtl/thermistor_adc_to_temperature.sv */
// NTC thermistor ADC sample to temperature in signed Q8 degrees C.
// Input channel: in_valid / in_stall with adc_sample; a transfer happens when
// in_valid is high and in_stall low. One sample is worked on at a time;
// in_stall is high from the transfer until the result is moved into the
// output register.
// Output channel: out_valid / out_stall with temperature_q8 and range_status.
// The result sits in an output register, so a new sample is taken while
// the previous result still waits on a stalled receiver; a result held by
// out_stall blocks only the finishing step of the next sample.
// Configuration: pullup_ohms written on cfg_valid (cfg_ready is always high).
// User must write only while the block is idle; the block does not enforce it.
// Processing: a full-scale sample goes straight to the finishing step; otherwise
// a serial multiplier, a 33-step radix-2 divider, a table search over the
// segments and an 11-step divide on the same divider; a clamped result skips
// the search and the second divide. These serial units set the rate:
// the next sample is taken the cycle after the result is registered.
// Reset clears the control state and sets pullup_ohms to 10000; no
// clearing pass is needed.
`default_nettype none

module thermistor_adc_to_temperature
	import ntc_adc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output      logic                     in_stall,
	input  wire logic [ADC_BITS-1:0]      adc_sample,
	output      logic                     out_valid,
	input  wire logic                     out_stall,
	output      logic signed [TEMP_W-1:0] temperature_q8,
	output      logic [1:0]               range_status,
	input  wire logic                     cfg_valid,
	output      logic                     cfg_ready,
	input  wire logic [PULLUP_W-1:0]      pullup_ohms
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_DIV1 = 6'b000100,
		S_SRCH = 6'b001000,
		S_DIV2 = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t                    state_q;
	logic [PULLUP_W-1:0]       pullup_q;
	logic [MCAND_W-1:0]        mcand_q;
	logic [ADC_BITS-1:0]       mbits_q;
	logic [ADC_BITS-1:0]       den_q;
	logic [PROD_W-1:0]         acc_q;
	logic [STEPS_W-1:0]        cnt_q;
	logic                      start_q;
	logic [RES_W-1:0]          r_q;
	logic [IDX_W-1:0]          idx_q;
	logic [DIV_W-1:0]          span_q;
	logic [NUM_W-1:0]          num_q;
	logic signed [TEMP_W-1:0]  res_temp_q;
	range_status_t             res_status_q;
	logic                      out_valid_q;
	logic signed [TEMP_W-1:0]  out_temp_q;
	logic [1:0]                out_status_q;

	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	logic [IDX_W-1:0]          idx_nxt;
	logic [RES_W-1:0]          res_hi;
	logic [RES_W-1:0]          res_lo;
	logic [DIV_W-1:0]          r_delta;
	logic                      out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign temperature_q8 = out_temp_q;
	assign range_status   = out_status_q;
	assign out_free  = ~out_valid_q | ~out_stall;

	assign idx_nxt = idx_q + IDX_W'(1);
	assign res_hi  = res_tenths(idx_q);
	assign res_lo  = res_tenths(idx_nxt);
	assign r_delta = DIV_W'(res_hi - r_q);

	ntc_adc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		div_req.start = start_q;
		if (state_q == S_DIV2) begin
			div_req.init_rem = num_q[NUM_W-1:QUO2_W];
			div_req.dividend = {num_q[QUO2_W-1:0], {(PROD_W-QUO2_W){1'b0}}};
			div_req.divisor  = span_q;
			div_req.steps    = STEPS_W'(QUO2_W);
		end else begin
			div_req.init_rem = '0;
			div_req.dividend = acc_q;
			div_req.divisor  = DIV_W'(den_q);
			div_req.steps    = STEPS_W'(PROD_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pullup_q <= PULLUP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pullup_q <= pullup_ohms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			start_q <= ((state_q == S_MUL) && (cnt_q == STEPS_W'(1))) ||
			           ((state_q == S_SRCH) && (r_q >= res_lo));
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q <= STEPS_W'(ADC_BITS);
						if (adc_sample == ADC_FULL) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q - STEPS_W'(1);
					if (cnt_q == STEPS_W'(1)) begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient >= PROD_W'(res_tenths(IDX_W'(0))) ||
						    div_rsp.quotient <=
						    PROD_W'(res_tenths(IDX_W'(TABLE_POINTS - 1)))) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (r_q >= res_lo) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mcand_q <= MCAND_W'({pullup_q, 3'b000}) + MCAND_W'({pullup_q, 1'b0});
				mbits_q <= adc_sample;
				den_q   <= ADC_FULL - adc_sample;
				acc_q   <= '0;
				// full-scale sample reads as the coldest entry
				res_temp_q   <= temp_base(IDX_W'(0));
				res_status_q <= RS_COLD;
			end
			S_MUL: begin
				acc_q   <= {acc_q[PROD_W-2:0], 1'b0} +
				           (mbits_q[ADC_BITS-1] ? PROD_W'(mcand_q) : PROD_W'(0));
				mbits_q <= {mbits_q[ADC_BITS-2:0], 1'b0};
			end
			S_DIV1: begin
				r_q   <= div_rsp.quotient[RES_W-1:0];
				idx_q <= '0;
				if (div_rsp.quotient >= PROD_W'(res_tenths(IDX_W'(0)))) begin
					res_temp_q   <= temp_base(IDX_W'(0));
					res_status_q <= RS_COLD;
				end else begin
					res_temp_q   <= temp_base(IDX_W'(TABLE_POINTS - 1));
					res_status_q <= RS_HOT;
				end
			end
			S_SRCH: begin
				// first segment whose lower end is at or below r
				if (r_q >= res_lo) begin
					span_q <= DIV_W'(res_hi - res_lo);
					num_q  <= NUM_W'({r_delta, 8'b0}) + NUM_W'({r_delta, 10'b0});
				end else begin
					idx_q <= idx_nxt;
				end
			end
			S_DIV2: begin
				res_temp_q   <= temp_base(idx_q) +
				                $signed({{(TEMP_W-QUO2_W){1'b0}},
				                         div_rsp.quotient[QUO2_W-1:0]});
				res_status_q <= RS_INTERP;
			end
			S_FIN: begin
				if (out_free) begin
					out_temp_q   <= res_temp_q;
					out_status_q <= res_status_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import ntc_adc_pkg::*;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		range_status_t            status;
	} temp_reading_t;

	localparam int COLD_Q8 = -5120;
	localparam int HOT_Q8  = 25600;
	localparam int STEP_Q8 = 1280;
	localparam int NUM_PHASES = 7;

	// thermistor resistance in tenths of an ohm, -20 C to 100 C in 5 C steps
	longint unsigned ntc_res [TABLE_POINTS] = '{
		1146600, 845100, 629270, 470770, 355630, 271190, 208600, 162040,
		126830, 100000, 79420, 63270, 50740, 41030, 33360, 27240,
		22370, 18460, 15300, 12750, 10680, 8993, 7607, 6452, 5494
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [ADC_BITS-1:0]      adc_sample = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [TEMP_W-1:0] temperature_q8;
	logic [1:0]               range_status;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [PULLUP_W-1:0]      pullup_ohms = PULLUP_RESET;

	logic [ADC_BITS-1:0] sample_q [$];
	temp_reading_t       reading_q [$];
	logic [PULLUP_W-1:0] pullup_model = PULLUP_RESET;
	logic                in_took = 1'b0;
	logic                calm = 1'b0;
	int                  in_gap = 0;
	int                  out_gap = 0;
	int                  long_hold_left = 0;
	logic                long_hold_used = 1'b0;
	int                  samples_taken = 0;
	int                  readings_checked = 0;
	int                  status_seen [3] = '{0, 0, 0};
	int                  errors = 0;

	thermistor_adc_to_temperature dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.temperature_q8 (temperature_q8),
		.range_status   (range_status),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.pullup_ohms    (pullup_ohms)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic temp_reading_t predict_reading(input logic [ADC_BITS-1:0] sample,
			input logic [PULLUP_W-1:0] pull);
		temp_reading_t   rd;
		longint unsigned r;
		longint unsigned span;
		longint unsigned offs;
		int              seg;
		seg = 0;
		if (sample == ADC_FULL) begin
			r = ntc_res[0];
		end else begin
			r = (64'(pull) * 64'd10 * 64'(sample)) / (64'(ADC_FULL) - 64'(sample));
		end
		if (r >= ntc_res[0]) begin
			rd.temp   = TEMP_W'(COLD_Q8);
			rd.status = RS_COLD;
		end else if (r <= ntc_res[TABLE_POINTS-1]) begin
			rd.temp   = TEMP_W'(HOT_Q8);
			rd.status = RS_HOT;
		end else begin
			// scan downward so the first bracketing segment wins
			for (int i = TABLE_POINTS - 2; i >= 0; i--) begin
				if (r <= ntc_res[i] && r >= ntc_res[i+1])
					seg = i;
			end
			span      = ntc_res[seg] - ntc_res[seg+1];
			offs      = ntc_res[seg] - r;
			rd.temp   = TEMP_W'(COLD_Q8 + STEP_Q8 * seg + int'((offs * 64'(STEP_Q8)) / span));
			rd.status = RS_INTERP;
		end
		return rd;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("tb: mismatch at %0t: %s", $realtime, what);
	endtask

	// sample both channels and the config port on the rising edge
	always @(posedge clk) begin
		temp_reading_t rd;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (reading_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result temp=%0d status=%0d",
						temperature_q8, range_status));
				end else begin
					rd = reading_q.pop_front();
					readings_checked++;
					if (range_status < 3)
						status_seen[range_status]++;
					if (temperature_q8 !== rd.temp)
						report_mismatch($sformatf("temperature_q8 %0d, want %0d",
							temperature_q8, rd.temp));
					if (range_status !== rd.status)
						report_mismatch($sformatf("range_status %0d, want %0d",
							range_status, rd.status));
				end
			end
			if (in_valid && !in_stall) begin
				reading_q.push_back(predict_reading(adc_sample, pullup_model));
				samples_taken++;
			end
			if (cfg_valid && cfg_ready)
				pullup_model <= pullup_ohms;
			in_took <= in_valid && !in_stall;
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (in_valid && !in_took) begin
			// hold the stalled transfer
		end else if (in_gap > 0) begin
			in_gap   <= in_gap - 1;
			in_valid <= 1'b0;
		end else if (sample_q.size() == 0) begin
			in_valid <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			in_gap   <= $urandom_range(0, 7);
			in_valid <= 1'b0;
		end else begin
			in_valid   <= 1'b1;
			adc_sample <= sample_q.pop_front();
		end
	end

	// long receiver hold-off, once, while the sender keeps offering
	always @(negedge clk) begin
		if (long_hold_left > 0) begin
			long_hold_left <= long_hold_left - 1;
		end else if (!long_hold_used && samples_taken == 200) begin
			long_hold_left <= 400;
			long_hold_used <= 1'b1;
		end
	end

	// result receiver stalls
	always @(negedge clk) begin
		if (long_hold_left > 0) begin
			out_stall <= 1'b1;
		end else if (out_gap > 0) begin
			out_gap   <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			out_gap   <= $urandom_range(0, 7);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic wait_drained();
		while (sample_q.size() != 0 || in_valid || reading_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_pullup(input logic [PULLUP_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid   <= 1'b1;
		pullup_ohms <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ADC_BITS-1:0] random_sample();
		logic [ADC_BITS-1:0] s;
		case ($urandom_range(0, 15))
			0:       s = ADC_FULL;
			1:       s = '0;
			2:       s = ADC_FULL - 1'b1;
			3:       s = ADC_BITS'($urandom_range(0, 3));
			default: s = ADC_BITS'($urandom_range(0, 4095));
		endcase
		return s;
	endfunction

	initial begin
		logic [PULLUP_W-1:0] phase_pullup [NUM_PHASES];
		int                  phase_items [NUM_PHASES];
		phase_pullup = '{PULLUP_W'(1000), PULLUP_W'(100000), '0, '1,
			PULLUP_W'($urandom_range(1000, 100000)),
			PULLUP_W'($urandom_range(1000, 100000)), PULLUP_RESET};
		phase_items = '{280, 280, 40, 250, 300, 300, 300};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, full scale, and one sample near every other table point
		sample_q.push_back('0);
		sample_q.push_back(ADC_BITS'(1));
		sample_q.push_back(ADC_FULL);
		sample_q.push_back(ADC_FULL - 1'b1);
		sample_q.push_back(ADC_BITS'('h555));
		sample_q.push_back(ADC_BITS'('hAAA));
		sample_q.push_back(ADC_BITS'(2048));
		for (int k = 0; k < TABLE_POINTS; k += 2)
			sample_q.push_back(ADC_BITS'((64'(ADC_FULL) * ntc_res[k]) /
				(ntc_res[k] + 64'd100000)));

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_pullup(phase_pullup[p]);
			if (p == NUM_PHASES - 1)
				calm = 1'b1;
			for (int n = 0; n < phase_items[p]; n++)
				sample_q.push_back(random_sample());
		end

		wait_drained();
		repeat (120) @(negedge clk);
		$display("tb: %0d samples checked over %0d pullup settings, 0 to 131071 ohms",
			readings_checked, NUM_PHASES + 1);
		$display("tb: interpolated %0d, cold clamp %0d, hot clamp %0d",
			status_seen[RS_INTERP], status_seen[RS_COLD], status_seen[RS_HOT]);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
